### rtl/core/moving_average_filter_core_defines.svh
// assertion macros shared by the moving-average filter rtl
`ifndef MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH
`define MOVING_AVERAGE_FILTER_CORE_DEFINES_SVH

// concurrent check, switched off while reset is high
`define MAVG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define MAVG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/mavg_pkg.sv
// shared types and constants of the moving-average filter
package mavg_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int AVG_W          = 24;
   localparam int WLEN_W         = 7;
   localparam int FRAC_SHIFT     = 8;
   localparam int MAX_WINDOW_DEF = 64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // register index of window_length
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

   localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(1);

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } div_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } div_stat_type;

endpackage

### rtl/core/mavg_cell.sv
// one cell of the delay line: loads the new sample at the tail, else its neighbour
module mavg_cell (
   input  logic                             clock,
   input  logic                             shift_en,
   input  logic                             is_tail,
   input  logic signed [mavg_pkg::SAMPLE_W-1:0] new_sample,
   input  logic signed [mavg_pkg::SAMPLE_W-1:0] neighbour,
   output logic signed [mavg_pkg::SAMPLE_W-1:0] data
);

   logic signed [mavg_pkg::SAMPLE_W-1:0] data_ff;
   logic signed [mavg_pkg::SAMPLE_W-1:0] data_in;

   // tail cell takes the incoming beat, the others move one place towards the head
   always_comb begin
      data_in = is_tail ? new_sample : neighbour;
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

### rtl/core/mavg_div.sv
// radix-2 restoring divider: window sum scaled by 256 over the window length
module mavg_div #(
   parameter int SUM_W = 22
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mavg_pkg::div_ctrl_type              ctrl,
   input  logic signed [SUM_W-1:0]             sum,
   input  logic [mavg_pkg::WLEN_W-1:0]         len,
   output mavg_pkg::div_stat_type              stat,
   output logic signed [mavg_pkg::AVG_W-1:0]   quotient
);

   localparam int NUM_W = SUM_W + mavg_pkg::FRAC_SHIFT;
   localparam int CNT_W = $clog2(NUM_W);
   localparam int DV_W  = mavg_pkg::WLEN_W;

   mavg_pkg::div_state_type state_ff, state_in;

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DV_W-1:0]  rem_ff, rem_in;
   logic [DV_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;

   logic [SUM_W-1:0] mag;
   logic [DV_W:0]    trial;
   logic             qbit;
   logic [mavg_pkg::AVG_W-1:0] qlow;

   // magnitude of the sum, the most negative value still fits unsigned
   always_comb begin
      mag = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
   end

   // one quotient bit a cycle
   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      qbit  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      stat     = '0;
      unique case (state_ff)
         mavg_pkg::DIV_IDLE: begin
            stat.idle = 1'b1;
            if (ctrl.start) begin
               num_in   = {mag, {mavg_pkg::FRAC_SHIFT{1'b0}}};
               rem_in   = '0;
               dvs_in   = len;
               cnt_in   = CNT_W'(NUM_W - 1);
               neg_in   = sum[SUM_W-1];
               state_in = mavg_pkg::DIV_RUN;
            end
         end
         mavg_pkg::DIV_RUN: begin
            rem_in = qbit ? DV_W'(trial - {1'b0, dvs_ff}) : trial[DV_W-1:0];
            num_in = {num_ff[NUM_W-2:0], qbit};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = mavg_pkg::DIV_DONE;
            end
         end
         mavg_pkg::DIV_DONE: begin
            stat.done = 1'b1;
            if (ctrl.ack) begin
               state_in = mavg_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = mavg_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mavg_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // sign restored on the low bits, the mean always fits the result width
   always_comb begin
      qlow     = num_ff[mavg_pkg::AVG_W-1:0];
      quotient = neg_ff ? (mavg_pkg::AVG_W'(0) - qlow) : qlow;
   end

endmodule

### rtl/core/moving_average_filter_core.sv
// top level of the boxcar moving-average filter
//
//   channel   direction   handshake          payload
//   req       in          req_valid/ready    req_sample, req_first
//   rsp       out         rsp_valid/ready    rsp_average
//   csr       in          apb psel/penable   paddr, pwdata, prdata
//
// a beat that yields no average leaves req_ready high; a beat that yields one
// keeps req_ready low until the one-bit-a-cycle divider has finished and its
// result is taken. reset is synchronous and needs no clearing pass: delay-line
// cells are read only after they are written. a stalled rsp beat keeps the next
// average in the divider, holding req_ready low until it moves.
`include "moving_average_filter_core_defines.svh"

module moving_average_filter_core #(
   parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mavg_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_first,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [mavg_pkg::AVG_W-1:0]    rsp_average,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [mavg_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mavg_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mavg_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int SUM_W = mavg_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int SW    = mavg_pkg::SAMPLE_W;
   localparam int WL    = mavg_pkg::WLEN_W;

   logic [WL-1:0]           wlen_ff, wlen_in;
   logic [WL-1:0]           fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [mavg_pkg::AVG_W-1:0] rsp_average_ff;

   logic [WL-1:0]           len;
   logic                    csr_wr;
   logic                    wl_wr;
   logic                    accept;
   logic [WL-1:0]           fill_eff;
   logic signed [SUM_W-1:0] sum_eff;
   logic signed [SUM_W-1:0] sub_val;
   logic signed [SUM_W-1:0] add_val;
   logic signed [SUM_W-1:0] sum_new;
   logic [WL-1:0]           fill_new;
   logic                    produce;
   logic                    load;

   logic signed [SW-1:0]    cell_data [MAX_WINDOW];

   mavg_pkg::div_ctrl_type            div_ctrl;
   mavg_pkg::div_stat_type            div_stat;
   logic signed [mavg_pkg::AVG_W-1:0] div_q;

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      wl_wr  = 1'b0;
      prdata = '0;
      unique case (paddr[mavg_pkg::CSR_ADDR_W-1:2])
         mavg_pkg::REG_WINDOW_LENGTH: begin
            wl_wr  = csr_wr;
            prdata = {{(mavg_pkg::CSR_DATA_W-WL){1'b0}}, wlen_ff};
         end
         default: begin
            wl_wr  = 1'b0;
            prdata = '0;
         end
      endcase
   end

   always_comb begin
      wlen_in = wl_wr ? pwdata[WL-1:0] : wlen_ff;
   end

   // effective window length, clamped to 1..MAX_WINDOW
   always_comb begin
      if (wlen_ff == '0) begin
         len = WL'(1);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         len = WL'(MAX_WINDOW);
      end else begin
         len = wlen_ff;
      end
   end

   assign req_ready = div_stat.idle;
   assign accept    = req_valid && req_ready;

   // running sum update: drop the oldest sample once the window is full
   always_comb begin
      fill_eff = req_first ? '0 : fill_ff;
      sum_eff  = req_first ? '0 : sum_ff;
      sub_val  = (fill_eff >= len) ? SUM_W'(cell_data[0]) : '0;
      add_val  = SUM_W'(req_sample);
      sum_new  = sum_eff - sub_val + add_val;
      fill_new = (fill_eff < len) ? (fill_eff + WL'(1)) : fill_eff;
      produce  = (fill_new >= len);
   end

   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (wl_wr) begin
         fill_in = '0;
         sum_in  = '0;
      end else if (accept) begin
         fill_in = fill_new;
         sum_in  = sum_new;
      end
   end

   // delay line: new samples enter at the tail, the oldest sits in cell 0
   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic                 tail;
      logic signed [SW-1:0] nb;
      assign tail = (32'(i) == (32'(len) - 32'd1));
      if (i == MAX_WINDOW - 1) begin : g_end
         assign nb = '0;
      end else begin : g_mid
         assign nb = cell_data[i+1];
      end
      mavg_cell u_cell (
         .clock      (clock),
         .shift_en   (accept),
         .is_tail    (tail),
         .new_sample (req_sample),
         .neighbour  (nb),
         .data       (cell_data[i])
      );
   end

   // divider and result register
   assign load           = div_stat.done && (!rsp_valid_ff || rsp_ready);
   assign div_ctrl.start = accept && produce;
   assign div_ctrl.ack   = load;

   mavg_div #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .sum      (sum_new),
      .len      (len),
      .stat     (div_stat),
      .quotient (div_q)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= mavg_pkg::WLEN_RESET;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wlen_ff      <= wlen_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_average_ff <= div_q;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // checks
   `MAVG_ASSERT(a_fill_in_window, clock, reset, (fill_ff <= len), "fill count beyond window")
   `MAVG_ASSERT(a_div_started, clock, reset, (div_ctrl.start |=> !div_stat.idle), "divider missed a start")
   `MAVG_ASSERT(a_rsp_from_div, clock, reset, ($rose(rsp_valid_ff) |-> $past(div_stat.done)), "result without a finished division")
   `MAVG_ASSERT_ALWAYS(a_reset_clears, clock, (reset |=> (!rsp_valid_ff && div_stat.idle)), "state left after reset")

endmodule
